[src/sdaf_pkg.sv]
// Shared constants and controller/datapath interface types for the
// signed decimal ASCII formatter. No dependencies.
package sdaf_pkg;

    // Default digit buffer depth: enough for any 32-bit magnitude
    localparam int MAX_DIGITS_DEF = 10;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    localparam logic [3:0]         RADIX      = 4'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture input, take magnitude
        logic mul;         // multiply magnitude by reciprocal
        logic div;         // finish divide step, store one digit
        logic emit_sign;   // load '-' into output register
        logic emit_digit;  // load next digit (MS first) into output register
    } sdaf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic negative;    // captured value was negative
        logic conv_done;   // current divide step produces the last digit
        logic digit_last;  // one digit left to emit
        logic out_free;    // output register can take a character now
    } sdaf_stat_t;

endpackage

[src/sdaf_dpath.sv]
// Datapath of the decimal formatter: magnitude register, reciprocal
// divide-by-ten unit, digit buffer and output register. Uses sdaf_pkg.
module sdaf_dpath #(
    parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [sdaf_pkg::VALUE_W-1:0]  in_value,
    input  sdaf_pkg::sdaf_cmd_t                  cmd,
    output sdaf_pkg::sdaf_stat_t                 stat,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [sdaf_pkg::CHAR_W-1:0]          m_tdata,
    output logic                                 m_tlast
);
    import sdaf_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int Q_W   = VALUE_W - (RECIP_SHIFT - VALUE_W);

    logic [VALUE_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic [2*VALUE_W-1:0] prod_reg;
    logic [CNT_W-1:0]     ndig_reg;
    logic [DIGIT_W-1:0]   digits_reg [MAX_DIGITS];
    logic                 tvalid_reg;
    logic [CHAR_W-1:0]    tdata_reg;
    logic                 tlast_reg;

    logic [Q_W-1:0]       quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [VALUE_W-1:0]   rem_full;
    logic [CNT_W-1:0]     rd_cnt;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W-1:0]     rd_idx;

    // Quotient and remainder from the registered reciprocal product
    assign quot     = prod_reg[2*VALUE_W-1:RECIP_SHIFT];
    assign quot_x10 = VALUE_W'(quot) * VALUE_W'(RADIX);
    assign rem_full = mag_reg - quot_x10;

    assign rd_cnt = ndig_reg - CNT_W'(1);
    assign wr_idx = IDX_W'(ndig_reg);
    assign rd_idx = IDX_W'(rd_cnt);

    // Status
    always_comb begin
        stat.negative   = neg_reg;
        stat.conv_done  = (quot == '0) || (ndig_reg == CNT_W'(MAX_DIGITS - 1));
        stat.digit_last = (ndig_reg == CNT_W'(1));
        stat.out_free   = !tvalid_reg || m_tready;
    end

    // Magnitude, product and digit count
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg  <= in_value[VALUE_W-1];
            mag_reg  <= in_value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(in_value))
                                            : $unsigned(in_value);
            ndig_reg <= '0;
        end else if (cmd.div) begin
            mag_reg  <= VALUE_W'(quot);
            ndig_reg <= ndig_reg + CNT_W'(1);
        end else if (cmd.emit_digit) begin
            ndig_reg <= rd_cnt;
        end
        if (cmd.mul) begin
            prod_reg <= (2*VALUE_W)'(mag_reg) * (2*VALUE_W)'(RECIP_10);
        end
    end

    // Digit buffer, least significant digit at index 0
    always_ff @(posedge aclk) begin
        if (cmd.div) begin
            digits_reg[wr_idx] <= rem_full[DIGIT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            tdata_reg <= CHAR_MINUS;
            tlast_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            tdata_reg <= CHAR_ZERO + CHAR_W'(digits_reg[rd_idx]);
            tlast_reg <= (ndig_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

[src/sdaf_ctrl.sv]
// Controller of the decimal formatter: sequences capture, divide steps
// and character output. Uses sdaf_pkg.
module sdaf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  sdaf_pkg::sdaf_stat_t  stat,
    output sdaf_pkg::sdaf_cmd_t   cmd
);
    import sdaf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (!stat.conv_done) begin
                    state_next = ST_MUL;
                end else if (stat.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (stat.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (stat.digit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/signed_decimal_ascii_formatter_core.sv]
// Top level of the signed decimal ASCII formatter: controller plus datapath.
// Uses sdaf_pkg, sdaf_ctrl and sdaf_dpath.

// Takes one signed 32-bit integer per request and sends its decimal text as
// ASCII characters, most significant digit first, with a leading '-' for
// negative values and m_tlast on the final character; zero gives "0" and
// -2147483648 prints in full. Each item runs a capture step, then per digit
// a divide step (a registered 32x32 reciprocal multiply, then remainder and
// digit store), then sends the '-', if any, and each digit through the single
// output register, which an output stall can hold. A new value is accepted
// as soon as the final character sits in the output register.
module signed_decimal_ascii_formatter_core #(
    parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic signed [sdaf_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sdaf_pkg::CHAR_W-1:0]          m_tdata,   // [7:0] character
    output logic                                 m_tlast
);
    import sdaf_pkg::*;

    sdaf_cmd_t  cmd;
    sdaf_stat_t stat;

    sdaf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdaf_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_value (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A sign character never ends a run
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == CHAR_MINUS) |-> !m_tlast)
        else $error("sign character flagged as last");

    // Only digits or the sign leave the block
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == CHAR_MINUS) ||
                     ((m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_NINE)))
        else $error("character outside digit/sign set");

    // A captured value keeps the input closed while it converts
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input reopened during conversion");

    // The sign is produced only for a negative value
    a_sign_only_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_sign |-> stat.negative)
        else $error("sign emitted for non-negative value");

endmodule
